// ----- rtl/rfpa_pkg.sv -----
package rfpa_pkg;

  // Register indexes of the configuration port.
  localparam logic [3:0] REG_ENABLE       = 4'd0;
  localparam logic [3:0] REG_SCREEN_WIDTH = 4'd1;
  localparam logic [3:0] REG_SCREEN_HGT   = 4'd2;
  localparam logic [3:0] REG_ROW_PITCH    = 4'd3;
  localparam logic [3:0] REG_DEPTH_IS_32  = 4'd4;
  localparam logic [3:0] REG_RED_LAYOUT   = 4'd5;
  localparam logic [3:0] REG_GREEN_LAYOUT = 4'd6;
  localparam logic [3:0] REG_BLUE_LAYOUT  = 4'd7;

  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 4;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [7:0] BYTE_MASK = 8'hFF;
  localparam int         WORD_W    = 32;

  typedef struct packed {
    logic              operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
  } rfpa_in_t;

  typedef struct packed {
    logic [23:0] pixel_color;
    logic        in_bounds;
  } rfpa_out_t;

  // One byte access request toward the frame store.
  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] wdata;
  } rfpa_mem_req_t;

  // Field size code, with codes above eight treated as eight.
  function automatic logic [3:0] lay_size(input logic [8:0] lay);
    logic [3:0] s;
    s = lay[3:0];
    return (s > 4'd8) ? 4'd8 : s;
  endfunction

  // Keep the top bits of a channel and move them to their bit position.
  function automatic logic [WORD_W-1:0] pack_chan(input logic [7:0] c,
                                                  input logic [8:0] lay);
    logic [3:0] sz;
    logic [7:0] v;
    sz = lay_size(lay);
    v  = c >> (4'd8 - sz);
    return {24'd0, v} << lay[8:4];
  endfunction

  // Pull a field out of the stored word and scale it back to eight bits.
  function automatic logic [7:0] unpack_chan(input logic [WORD_W-1:0] raw,
                                             input logic [8:0] lay);
    logic [3:0]        sz;
    logic [WORD_W-1:0] sh;
    logic [7:0]        mask;
    logic [7:0]        field;
    sz    = lay_size(lay);
    sh    = raw >> lay[8:4];
    mask  = 8'((9'd1 << sz) - 9'd1);
    field = sh[7:0] & mask;
    return BYTE_MASK & (field << (4'd8 - sz));
  endfunction

endpackage

// ----- rtl/rfpa_store.sv -----
module rfpa_store
  import rfpa_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rfpa_mem_req_t req,
  input  logic [AW-1:0] addr,
  output logic [7:0]    rd_data,
  output logic          clearing
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clearing_r, clearing_nxt;
  logic [7:0]    rd_data_r;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  // Single port: the clearing sweep owns the port until it finishes.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (req.en && req.we) begin
      mem[addr] <= req.wdata;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

// ----- rtl/rgb_framebuffer_pixel_access.sv -----
// Channel   Ports                               Transaction taken when
// input     start, busy, in_item                start high and busy low at a clock edge
// result    out_valid, out_item                 out_valid high (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_data         cfg_we high at a clock edge
//
// A write steps through S_ADDR, S_CHECK and one S_WR state per byte, and a read
// through S_ADDR, S_CHECK, one S_RD state per byte, S_RDWAIT and S_FIN. A pixel
// has 3 or 4 bytes, each moved in a cycle of its own through the single byte-wide
// port of the frame store. Refused accesses end after S_CHECK. After reset, busy
// stays high while the frame store is swept to zero. Reset is synchronous and
// active low. The receiver cannot stall: each read result is shown for exactly one cycle.
module rgb_framebuffer_pixel_access
  import rfpa_pkg::*;
#(
  parameter int STORE_BYTES = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rfpa_in_t              in_item,
  output logic                  out_valid,
  output rfpa_out_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(STORE_BYTES);
  localparam int SUM_W = 30;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ADDR   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_WR     = 7'b0001000,
    S_RD     = 7'b0010000,
    S_RDWAIT = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic        enable_r;
  logic [12:0] screen_width_r;
  logic [12:0] screen_height_r;
  logic [14:0] row_pitch_r;
  logic        depth_is_32_r;
  logic [8:0]  red_layout_r;
  logic [8:0]  green_layout_r;
  logic [8:0]  blue_layout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r        <= 1'b0;
      screen_width_r  <= 13'd64;
      screen_height_r <= 13'd64;
      row_pitch_r     <= 15'd256;
      depth_is_32_r   <= 1'b1;
      red_layout_r    <= 9'd264;
      green_layout_r  <= 9'd136;
      blue_layout_r   <= 9'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       enable_r        <= cfg_data[0];
        REG_SCREEN_WIDTH: screen_width_r  <= cfg_data[12:0];
        REG_SCREEN_HGT:   screen_height_r <= cfg_data[12:0];
        REG_ROW_PITCH:    row_pitch_r     <= cfg_data[14:0];
        REG_DEPTH_IS_32:  depth_is_32_r   <= cfg_data[0];
        REG_RED_LAYOUT:   red_layout_r    <= cfg_data[8:0];
        REG_GREEN_LAYOUT: green_layout_r  <= cfg_data[8:0];
        REG_BLUE_LAYOUT:  blue_layout_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Datapath registers; of these only out_valid_r and rd_pend_r are reset.
  rfpa_in_t          item_r;
  logic [27:0]       prod_r;
  logic              ok_r;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] raw_r;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [1:0]        rd_idx_r;
  logic              rd_pend_r;
  logic              out_valid_r, out_valid_nxt;
  rfpa_out_t         out_item_r, out_item_nxt;

  logic [7:0]    rd_data;
  logic          clearing;
  rfpa_mem_req_t mem_req;

  rfpa_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .addr     (addr_r),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Byte offset of the pixel within its row: x times three or four.
  logic [12:0]      x_low;
  logic [14:0]      x_off;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] end_addr;
  logic [1:0]       last_idx;
  logic             coord_ok;
  logic             fits;

  assign x_low    = item_r.pos_x[12:0];
  assign x_off    = depth_is_32_r ? {x_low, 2'b00} : ({2'b00, x_low} + {1'b0, x_low, 1'b0});
  assign sum      = SUM_W'(prod_r) + SUM_W'(x_off);
  assign end_addr = sum + (depth_is_32_r ? SUM_W'(4) : SUM_W'(3));
  assign fits     = (end_addr <= SUM_W'(STORE_BYTES));
  assign last_idx = depth_is_32_r ? 2'd3 : 2'd2;

  // The block must be enabled, and coordinates must be non-negative and inside the visible area.
  assign coord_ok = enable_r
                 && !item_r.pos_x[15] && !item_r.pos_y[15]
                 && (item_r.pos_x[14:0] < {2'b00, screen_width_r})
                 && (item_r.pos_y[14:0] < {2'b00, screen_height_r});

  assign busy = clearing || (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (start && !clearing) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        // The packed word is built here while the row product settles.
        word_nxt  = pack_chan(item_r.red_in, red_layout_r)
                  | pack_chan(item_r.green_in, green_layout_r)
                  | pack_chan(item_r.blue_in, blue_layout_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        addr_nxt = sum[AW-1:0];
        idx_nxt  = 2'd0;
        if (ok_r && fits) begin
          state_nxt = (item_r.operation == OP_READ) ? S_RD : S_WR;
        end else begin
          state_nxt = S_IDLE;
          if (item_r.operation == OP_READ) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end
        end
      end
      S_WR: begin
        // One byte per cycle, least significant byte first.
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = word_r[7:0];
        word_nxt      = word_r >> 8;
        addr_nxt      = addr_r + AW'(1);
        idx_nxt       = idx_r + 2'd1;
        if (idx_r == last_idx) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        mem_req.en = 1'b1;
        addr_nxt   = addr_r + AW'(1);
        idx_nxt    = idx_r + 2'd1;
        if (idx_r == last_idx) begin
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        // The last byte lands in the gathered word during this cycle.
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt            = 1'b1;
        out_item_nxt.pixel_color = {unpack_chan(raw_r, red_layout_r),
                                    unpack_chan(raw_r, green_layout_r),
                                    unpack_chan(raw_r, blue_layout_r)};
        out_item_nxt.in_bounds   = 1'b1;
        state_nxt                = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= (state_r == S_RD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && !clearing) begin
      item_r <= in_item;
    end
    if (state_r == S_ADDR) begin
      prod_r <= 28'(item_r.pos_y[12:0]) * 28'(row_pitch_r);
      ok_r   <= coord_ok;
    end
    // A 24-bit pixel leaves the top byte of the gathered word at zero.
    if (state_r == S_CHECK) begin
      raw_r <= '0;
    end else if (rd_pend_r) begin
      raw_r[{rd_idx_r, 3'b000} +: 8] <= rd_data;
    end
    rd_idx_r   <= idx_r;
    addr_r     <= addr_nxt;
    idx_r      <= idx_nxt;
    word_r     <= word_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- tb/sv/tb_rgb_framebuffer_pixel_access.sv -----
`timescale 1ns / 100ps

module tb_rgb_framebuffer_pixel_access;
  import rfpa_pkg::*;

  localparam int STORE_BYTES  = 16384;
  // The limit leaves a wide margin over a normal run, clearing sweep after reset included.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PERCENT = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 120;
  // Transactions in this window are offered with no random idle gap before them.
  localparam int STEADY_FIRST = 350;
  localparam int STEADY_LAST  = 500;
  // Cycles to let a write finish after its transaction has been accepted, since a
  // write gives no result to wait for.
  localparam int WRITE_DRAIN  = 8;
  localparam int POOL_MAX     = 64;
  // An index above the last register. The block must ignore writes to it.
  localparam logic [3:0] REG_UNMAPPED = 4'd15;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_t;

  // One row of the directed table. It is either a register write or a pixel
  // transaction. A read row may carry a result typed in by hand.
  typedef struct {
    row_kind_t  kind;
    logic [3:0] reg_idx;
    logic [14:0] reg_val;
    rfpa_in_t   item;
    bit         fixed;
    rfpa_out_t  fixed_res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  rfpa_in_t              in_item = '0;
  logic                  out_valid;
  rfpa_out_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Our own copy of the frame store and of the registers. The store starts
  // out cleared, just as the block sweeps its store to zero after reset.
  logic [7:0]  mirror_bytes [STORE_BYTES];
  logic        en_q        = 1'b0;
  logic [12:0] width_q     = 13'd64;
  logic [12:0] height_q    = 13'd64;
  logic [14:0] pitch_q     = 15'd256;
  logic        depth32_q   = 1'b1;
  logic [8:0]  red_lay_q   = 9'd264;
  logic [8:0]  green_lay_q = 9'd136;
  logic [8:0]  blue_lay_q  = 9'd8;

  // Read results that are still owed by the block, oldest first.
  rfpa_out_t   pending_reads [$];
  // Coordinates that were written recently, so that reads can hit them.
  logic [31:0] drawn_spots [$];

  int errors       = 0;
  int cycles       = 0;
  int items_sent   = 0;
  int writes_sent  = 0;
  int reads_seen   = 0;
  int reads_hit    = 0;
  int reg_writes   = 0;

  rgb_framebuffer_pixel_access #(
    .STORE_BYTES(STORE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    foreach (mirror_bytes[i]) mirror_bytes[i] = 8'h00;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A size code above eight counts as eight.
  function automatic int unsigned field_size(input logic [8:0] lay);
    return (lay[3:0] > 4'd8) ? 8 : int'(lay[3:0]);
  endfunction

  // Keep the top bits of an intensity and move them up to their field. Bits
  // pushed above bit 31 of the pixel word are dropped.
  function automatic logic [31:0] place_field(input logic [7:0] c, input logic [8:0] lay);
    logic [63:0] v;
    v = 64'(c) >> (8 - field_size(lay));
    v = v << lay[8:4];
    return v[31:0];
  endfunction

  // Mask a field out of the stored word and scale it back up to eight bits.
  function automatic logic [7:0] take_field(input logic [31:0] raw, input logic [8:0] lay);
    logic [31:0] f;
    int unsigned sz;
    sz = field_size(lay);
    f  = (raw >> lay[8:4]) & ((32'd1 << sz) - 32'd1);
    f  = f << (8 - sz);
    return f[7:0];
  endfunction

  // Works out where a pixel lives. It returns 0 when the access is refused:
  // the block is disabled, a coordinate is negative or off screen, or one of
  // the pixel's bytes would fall outside the store.
  function automatic bit locate_pixel(input logic [15:0] x, input logic [15:0] y,
                                      output longint unsigned addr,
                                      output int unsigned nbytes);
    longint unsigned a;
    nbytes = depth32_q ? 4 : 3;
    addr   = 0;
    if (!en_q || x[15] || y[15]) return 1'b0;
    if (x >= width_q || y >= height_q) return 1'b0;
    a = 64'(y) * 64'(pitch_q) + 64'(x) * 64'(nbytes);
    if (a + 64'(nbytes) > 64'(STORE_BYTES)) return 1'b0;
    addr = a;
    return 1'b1;
  endfunction

  // Applies one pixel transaction to the mirror. It returns 1 when the
  // transaction is a read, which always answers, with the answer in res.
  function automatic bit pixel_access(input rfpa_in_t it, output rfpa_out_t res);
    longint unsigned addr;
    int unsigned nbytes;
    int unsigned i;
    bit ok;
    logic [31:0] word;
    logic [31:0] raw;
    res = '0;
    ok  = locate_pixel(it.pos_x, it.pos_y, addr, nbytes);
    if (it.operation == OP_WRITE) begin
      if (ok) begin
        word = place_field(it.red_in, red_lay_q) | place_field(it.green_in, green_lay_q)
             | place_field(it.blue_in, blue_lay_q);
        for (i = 0; i < nbytes; i++) mirror_bytes[addr + i] = word[8*i +: 8];
      end
      return 1'b0;
    end
    if (ok) begin
      raw = '0;
      for (i = 0; i < nbytes; i++) raw |= 32'(mirror_bytes[addr + i]) << (8 * i);
      res.pixel_color = {take_field(raw, red_lay_q), take_field(raw, green_lay_q),
                         take_field(raw, blue_lay_q)};
      res.in_bounds   = 1'b1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Writes one register and mirrors it. The write enable is left high, so
  // that back-to-back register writes need no extra cycle. The next pixel
  // transaction or the next pause lowers it again.
  task automatic write_reg(input logic [3:0] idx, input logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_ENABLE:       en_q        = val[0];
      REG_SCREEN_WIDTH: width_q     = val[12:0];
      REG_SCREEN_HGT:   height_q    = val[12:0];
      REG_ROW_PITCH:    pitch_q     = val[14:0];
      REG_DEPTH_IS_32:  depth32_q   = val[0];
      REG_RED_LAYOUT:   red_lay_q   = val[8:0];
      REG_GREEN_LAYOUT: green_lay_q = val[8:0];
      REG_BLUE_LAYOUT:  blue_lay_q  = val[8:0];
      default: ;
    endcase
  endtask

  // Brings the block to rest. It waits for every read result that is owed
  // and for busy to drop. It then gives a trailing write time to finish,
  // since a write gives no result that could be waited for.
  task automatic settle();
    start  <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (WRITE_DRAIN) @(posedge clk);
  endtask

  // Offers one pixel transaction and holds it until it is accepted. An idle
  // gap of random length may come first. Start is only lowered here when
  // such a gap is taken, so a run of transactions keeps it high throughout.
  task automatic push_item(input rfpa_in_t it, input bit fixed, input rfpa_out_t fixed_res);
    rfpa_out_t res;
    bit answers;
    cfg_we <= 1'b0;
    if (!(items_sent >= STEADY_FIRST && items_sent < STEADY_LAST) &&
        $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The transaction was taken at this edge. The predictor and the block
    // now see the same sequence of transactions.
    answers = pixel_access(it, res);
    if (answers) pending_reads.push_back(fixed ? fixed_res : res);
    else writes_sent++;
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_row_t access_row(input logic op, input int x, input int y,
                                           input logic [23:0] rgb);
    stim_row_t r;
    r.kind               = ROW_ACCESS;
    r.reg_idx            = REG_ENABLE;
    r.reg_val            = '0;
    r.item.operation     = op;
    r.item.pos_x         = 16'(x);
    r.item.pos_y         = 16'(y);
    r.item.red_in        = rgb[23:16];
    r.item.green_in      = rgb[15:8];
    r.item.blue_in       = rgb[7:0];
    r.fixed              = 1'b0;
    r.fixed_res          = '0;
    return r;
  endfunction

  // A read whose answer is obvious and is therefore typed in directly.
  function automatic stim_row_t known_read(input int x, input int y,
                                           input logic [23:0] color, input logic hit);
    stim_row_t r;
    r                       = access_row(OP_READ, x, y, 24'h000000);
    r.fixed                 = 1'b1;
    r.fixed_res.pixel_color = color;
    r.fixed_res.in_bounds   = hit;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [3:0] idx, input logic [14:0] val);
    stim_row_t r;
    r         = access_row(OP_WRITE, 0, 0, 24'h000000);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [8:0] random_layout();
    if ($urandom_range(0, 1) == 0) return 9'($urandom);
    // A byte-aligned field of a sane size, as real pixel formats use.
    return {5'($urandom_range(0, 3) * 8), 4'($urandom_range(1, 8))};
  endfunction

  // Mostly coordinates inside the current screen, with read-backs of pixels
  // drawn earlier. The rest is boundary coordinates and raw noise.
  function automatic rfpa_in_t random_item();
    rfpa_in_t it;
    int unsigned pick;
    int unsigned xmax;
    int unsigned ymax;
    logic [31:0] spot;
    it.operation = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_READ;
    it.red_in    = 8'($urandom);
    it.green_in  = 8'($urandom);
    it.blue_in   = 8'($urandom);
    xmax = (width_q == 0) ? 0 : width_q - 1;
    if (xmax > 5600) xmax = 5600;
    ymax = (height_q == 0) ? 0 : height_q - 1;
    if (ymax > 70) ymax = 70;
    if (pitch_q > STORE_BYTES && ymax > 1) ymax = 1;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it.pos_x = 16'($urandom);
      it.pos_y = 16'($urandom);
    end else if (pick < 14) begin
      case ($urandom_range(0, 3))
        0: begin it.pos_x = 16'(width_q); it.pos_y = 16'($urandom_range(0, ymax)); end
        1: begin it.pos_x = 16'hFFFF;     it.pos_y = 16'($urandom_range(0, ymax)); end
        2: begin it.pos_x = 16'($urandom_range(0, xmax)); it.pos_y = 16'(height_q); end
        default: begin it.pos_x = 16'(xmax); it.pos_y = 16'(ymax); end
      endcase
    end else if (it.operation == OP_READ && drawn_spots.size() != 0 && pick < 60) begin
      spot     = drawn_spots[$urandom_range(0, drawn_spots.size() - 1)];
      it.pos_x = spot[31:16];
      it.pos_y = spot[15:0];
    end else begin
      it.pos_x = 16'($urandom_range(0, xmax));
      it.pos_y = 16'($urandom_range(0, ymax));
    end
    if (it.operation == OP_WRITE) begin
      drawn_spots.push_back({it.pos_x, it.pos_y});
      if (drawn_spots.size() > POOL_MAX) void'(drawn_spots.pop_front());
    end
    return it;
  endfunction

  initial begin : stimulus
    stim_row_t   rows [$];
    stim_row_t   row;
    bit          after_reg;
    int          p;
    int          n;
    logic [14:0] w_v;
    logic [14:0] h_v;
    logic [14:0] pitch_v;
    logic        depth_v;
    logic        en_v;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset settings the block is disabled. A read is refused, and
    // a write must leave the store untouched.
    rows.push_back(known_read(0, 0, 24'h000000, 1'b0));
    rows.push_back(access_row(OP_WRITE, 5, 5, 24'hFFFFFF));
    rows.push_back(reg_row(REG_ENABLE, 15'd1));
    rows.push_back(reg_row(REG_UNMAPPED, 15'h7FFF));
    rows.push_back(known_read(5, 5, 24'h000000, 1'b1));
    // Reset layout is plain 8:8:8 at bits 16, 8 and 0 in 32-bit pixels.
    rows.push_back(access_row(OP_WRITE, 0, 0, 24'h123456));
    rows.push_back(known_read(0, 0, 24'h123456, 1'b1));
    // The bottom-right pixel takes exactly the last four bytes of the store.
    rows.push_back(access_row(OP_WRITE, 63, 63, 24'hFFFFFF));
    rows.push_back(known_read(63, 63, 24'hFFFFFF, 1'b1));
    rows.push_back(known_read(64, 0, 24'h000000, 1'b0));
    rows.push_back(known_read(0, 64, 24'h000000, 1'b0));
    rows.push_back(known_read(-1, 0, 24'h000000, 1'b0));
    rows.push_back(known_read(0, -32768, 24'h000000, 1'b0));
    rows.push_back(known_read(32767, 32767, 24'h000000, 1'b0));
    rows.push_back(access_row(OP_WRITE, -32768, 5, 24'hA5A5A5));
    rows.push_back(access_row(OP_READ, 0, 5, 24'h000000));
    // Odd layouts: an empty red field, a green field that runs off the top
    // of the word, and a blue size code above eight.
    rows.push_back(reg_row(REG_RED_LAYOUT, 15'(28 * 16 + 0)));
    rows.push_back(reg_row(REG_GREEN_LAYOUT, 15'(30 * 16 + 8)));
    rows.push_back(reg_row(REG_BLUE_LAYOUT, 15'(0 * 16 + 15)));
    rows.push_back(access_row(OP_WRITE, 1, 1, 24'hABCDEF));
    rows.push_back(access_row(OP_READ, 1, 1, 24'h000000));
    // In 24-bit pixels, a red field in the top byte is never stored.
    rows.push_back(reg_row(REG_DEPTH_IS_32, 15'd0));
    rows.push_back(reg_row(REG_RED_LAYOUT, 15'(24 * 16 + 8)));
    rows.push_back(access_row(OP_WRITE, 2, 2, 24'hFF807F));
    rows.push_back(access_row(OP_READ, 2, 2, 24'h000000));
    // All ones in the size registers, which the block cuts to their widths.
    // The store, not the screen, now limits which pixels can be reached.
    rows.push_back(reg_row(REG_SCREEN_WIDTH, 15'h7FFF));
    rows.push_back(reg_row(REG_SCREEN_HGT, 15'h7FFF));
    rows.push_back(reg_row(REG_ROW_PITCH, 15'h7FFF));
    rows.push_back(access_row(OP_WRITE, 4095, 0, 24'h5AC33C));
    rows.push_back(access_row(OP_READ, 4095, 0, 24'h000000));
    rows.push_back(access_row(OP_READ, 5460, 0, 24'h000000));
    rows.push_back(known_read(5461, 0, 24'h000000, 1'b0));
    rows.push_back(known_read(0, 1, 24'h000000, 1'b0));
    rows.push_back(reg_row(REG_SCREEN_WIDTH, 15'd0));
    rows.push_back(known_read(0, 0, 24'h000000, 1'b0));
    // A zero pitch folds every row onto the first one.
    rows.push_back(reg_row(REG_ROW_PITCH, 15'd0));
    rows.push_back(reg_row(REG_SCREEN_WIDTH, 15'd64));
    rows.push_back(reg_row(REG_SCREEN_HGT, 15'd64));
    rows.push_back(access_row(OP_WRITE, 3, 9, 24'h112233));
    rows.push_back(access_row(OP_READ, 3, 40, 24'h000000));

    after_reg = 1'b0;
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_REG) begin
        if (!after_reg) settle();
        write_reg(row.reg_idx, row.reg_val);
        after_reg = 1'b1;
      end else begin
        push_item(row.item, row.fixed, row.fixed_res);
        after_reg = 1'b0;
      end
    end

    // Random phases. Each phase first sets every register. Most phases use a
    // small screen that fits the store, or just overruns it. Some phases use
    // the extremes: no columns, no rows, the largest sizes, no pitch, or disabled.
    for (p = 0; p < PHASES; p++) begin
      settle();
      depth_v = 1'($urandom_range(0, 1));
      en_v    = (p == 5) ? 1'b0 : 1'b1;
      w_v     = 15'($urandom_range(1, 64));
      h_v     = 15'($urandom_range(1, 64));
      pitch_v = 15'(w_v * (depth_v ? 4 : 3) + $urandom_range(0, 16));
      if ($urandom_range(0, 3) == 0) pitch_v = 15'($urandom_range(0, 400));
      case (p)
        2: w_v = 15'd0;
        3: begin w_v = 15'h7FFF; h_v = 15'h7FFF; pitch_v = 15'h7FFF; end
        4: pitch_v = 15'd0;
        6: h_v = 15'd0;
        default: ;
      endcase
      write_reg(REG_ENABLE, 15'(en_v));
      write_reg(REG_SCREEN_WIDTH, w_v);
      write_reg(REG_SCREEN_HGT, h_v);
      write_reg(REG_ROW_PITCH, pitch_v);
      write_reg(REG_DEPTH_IS_32, 15'(depth_v));
      write_reg(REG_RED_LAYOUT, 15'(random_layout()));
      write_reg(REG_GREEN_LAYOUT, 15'(random_layout()));
      write_reg(REG_BLUE_LAYOUT, 15'(random_layout()));
      drawn_spots.delete();
      for (n = 0; n < PHASE_ITEMS; n++) push_item(random_item(), 1'b0, '0);
    end

    settle();
    repeat (WRITE_DRAIN) @(posedge clk);
    $display("Sent %0d pixel transactions (%0d writes) and %0d register writes over %0d phases.",
             items_sent, writes_sent, reg_writes, PHASES + 1);
    $display("Checked %0d read results, %0d inside the frame and %0d refused.",
             reads_seen, reads_hit, reads_seen - reads_hit);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("tb_rgb_framebuffer_pixel_access: clean");
    end else begin
      $display("tb_rgb_framebuffer_pixel_access: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Every result is shown for exactly one cycle and cannot be held off. It is
  // taken at the edge that ends that cycle, and it must match the oldest
  // read still owed.
  always @(posedge clk) begin : check_results
    rfpa_out_t want;
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result %06h/%0b arrived with no read outstanding",
                   $realtime, out_item.pixel_color, out_item.in_bounds);
      end else begin
        want = pending_reads.pop_front();
        reads_seen++;
        if (out_item.in_bounds === 1'b1) reads_hit++;
        if (out_item.pixel_color !== want.pixel_color ||
            out_item.in_bounds !== want.in_bounds) begin
          errors++;
          if (errors <= 10)
            $display("%0t: read %0d: pixel_color %06h in_bounds %0b, wanted %06h %0b",
                     $realtime, reads_seen, out_item.pixel_color, out_item.in_bounds,
                     want.pixel_color, want.in_bounds);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Gave up after %0d cycles with %0d reads outstanding.",
               cycles, pending_reads.size());
      $display("tb_rgb_framebuffer_pixel_access: errors");
      $finish;
    end
  end

endmodule

// ----- rgb_framebuffer_pixel_access.f -----
rtl/rfpa_pkg.sv
rtl/rfpa_store.sv
rtl/rgb_framebuffer_pixel_access.sv
tb/sv/tb_rgb_framebuffer_pixel_access.sv
